[rtl/core/iff_pkg.sv]
// ---------------------------------------------------------------------------
// iff_pkg
// Shared types, widths, character codes and helpers of the integer field
// formatter.
// ---------------------------------------------------------------------------
package iff_pkg;

  // Field widths of the input and result transactions.
  localparam int VALUE_W = 32;
  localparam int BASE_W  = 6;
  localparam int FW_W    = 7;
  localparam int MD_W    = 6;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 6;
  // Width of every length, boundary and position inside one field.
  localparam int LEN_W   = 8;

  // Base limits and the bases that carry an alternate prefix.
  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
  localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;
  localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_X       = 8'h78;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CHECK,
    S_DIVIDE,
    S_SIZE,
    S_BOUND,
    S_EMIT,
    S_ERROR
  } iff_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start_div;
    logic store_digit;
    logic store_zero;
    logic size;
    logic bound;
    logic emit;
    logic emit_err;
  } iff_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic base_bad;
    logic quot_zero;
    logic dc_zero;
    logic digits_full;
    logic div_done;
    logic slot_free;
    logic emit_last;
  } iff_sts_t;

  // ASCII character of one digit value, letters above nine.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                    input logic upper);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 6'd10) begin
      digit_char = CH_ZERO + d_ext;
    end else begin
      digit_char = (upper ? CH_UPPER_A : CH_LOWER_A) + d_ext - 8'd10;
    end
  endfunction

endpackage

[rtl/core/iff_in_if.sv]
// ---------------------------------------------------------------------------
// iff_in_if
// Input channel: one value with its conversion spec per transaction.
// ---------------------------------------------------------------------------
interface iff_in_if;
  logic                           valid;
  logic                           ready;
  logic [iff_pkg::VALUE_W-1:0]    value;
  logic [iff_pkg::BASE_W-1:0]     base;
  logic [iff_pkg::FW_W-1:0]       field_width;
  logic [iff_pkg::MD_W-1:0]       min_digits;
  logic                           signed_conv;
  logic                           force_plus;
  logic                           space_sign;
  logic                           alt_prefix;
  logic                           zero_pad;
  logic                           left_align;
  logic                           upper_digits;

  modport source (
    output valid, value, base, field_width, min_digits, signed_conv, force_plus,
           space_sign, alt_prefix, zero_pad, left_align, upper_digits,
    input  ready
  );

  modport sink (
    input  valid, value, base, field_width, min_digits, signed_conv, force_plus,
           space_sign, alt_prefix, zero_pad, left_align, upper_digits,
    output ready
  );
endinterface

[rtl/core/iff_out_if.sv]
// ---------------------------------------------------------------------------
// iff_out_if
// Result channel: one formatted character per transaction.
// ---------------------------------------------------------------------------
interface iff_out_if;
  logic                        valid;
  logic                        ready;
  logic [iff_pkg::CHAR_W-1:0]  char_out;
  logic                        last;
  logic                        error;

  modport source (
    output valid, char_out, last, error,
    input  ready
  );

  modport sink (
    input  valid, char_out, last, error,
    output ready
  );
endinterface

[rtl/core/iff_div.sv]
// ---------------------------------------------------------------------------
// iff_div
// Restoring radix-2 divider: a 32-bit dividend by a 6-bit base, one
// quotient bit per cycle; done pulses in the cycle after the last step.
// ---------------------------------------------------------------------------
module iff_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [iff_pkg::VALUE_W-1:0]    dividend,
  input  logic [iff_pkg::BASE_W-1:0]     divisor,
  output logic                           done,
  output logic [iff_pkg::VALUE_W-1:0]    quotient,
  output logic [iff_pkg::DIGIT_W-1:0]    remainder
);

  localparam int CNT_W = $clog2(iff_pkg::VALUE_W);

  logic [iff_pkg::VALUE_W-1:0] q_r, q_nxt;
  logic [iff_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [iff_pkg::DIGIT_W:0]   partial;
  logic [iff_pkg::DIGIT_W:0]   diff;

  // One shift-and-subtract step.
  always_comb begin
    partial  = {rem_r, q_r[iff_pkg::VALUE_W-1]};
    diff     = partial - {1'b0, divisor};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (partial >= {1'b0, divisor}) begin
        rem_nxt = diff[iff_pkg::DIGIT_W-1:0];
        q_nxt   = {q_r[iff_pkg::VALUE_W-2:0], 1'b1};
      end else begin
        rem_nxt = partial[iff_pkg::DIGIT_W-1:0];
        q_nxt   = {q_r[iff_pkg::VALUE_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(iff_pkg::VALUE_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Step registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

[rtl/core/iff_dpath.sv]
// ---------------------------------------------------------------------------
// iff_dpath
// Datapath: spec registers, sign and magnitude, digit store, field layout
// and the output register that emits one character per transaction.
// ---------------------------------------------------------------------------
module iff_dpath #(
  parameter int MAX_DIGITS    = 32,
  parameter int MAX_OUT_CHARS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  iff_pkg::iff_cmd_t cmd,
  output iff_pkg::iff_sts_t sts,
  iff_in_if.sink            in_ch,
  iff_out_if.source         out_ch
);

  localparam int AW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW    = $clog2(MAX_DIGITS + 1);
  localparam int LEN_W = iff_pkg::LEN_W;
  localparam logic [LEN_W-1:0] OUT_LIMIT = LEN_W'(MAX_OUT_CHARS);

  // Spec registers.
  logic [iff_pkg::BASE_W-1:0]  base_r;
  logic [iff_pkg::FW_W-1:0]    fw_r;
  logic [iff_pkg::MD_W-1:0]    md_r;
  logic                        left_r, zpad_r, upper_r;
  logic [iff_pkg::CHAR_W-1:0]  sign_ch_r, sign_ch_nxt;
  logic                        sl_r, sl_nxt;
  logic [1:0]                  pl_r, pl_nxt;
  logic [iff_pkg::VALUE_W-1:0] mag;

  // Conversion state.
  logic [iff_pkg::VALUE_W-1:0] quot_r, quot_nxt;
  logic [CW-1:0]               dc_r, dc_nxt;
  logic [iff_pkg::DIGIT_W-1:0] digit_mem [MAX_DIGITS];
  logic [iff_pkg::DIGIT_W-1:0] rd_data_r;
  logic [AW-1:0]               rd_idx_r, rd_idx_nxt;

  // Layout registers.
  logic [LEN_W-1:0] lead_r, zfill_r, pzero_r, trail_r;
  logic [LEN_W-1:0] b1_r, b2_r, b3_r, b4_r, b5_r, limit_r;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] dc_len, md_len, prec, fixed, fw_len, pad;
  logic [LEN_W-1:0] b2_c, b3_c, b4_c, b5_c, total_c;

  // Output register.
  logic                        out_valid_r;
  logic [iff_pkg::CHAR_W-1:0]  out_char_r, char_c;
  logic                        out_last_r, out_err_r;
  logic                        in_digits, emit_last;

  // Divider.
  logic                        div_done;
  logic [iff_pkg::VALUE_W-1:0] div_q;
  logic [iff_pkg::DIGIT_W-1:0] div_rem;

  iff_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.start_div),
    .dividend  (quot_r),
    .divisor   (base_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // Sign character, magnitude and prefix length of the incoming transaction.
  always_comb begin
    sign_ch_nxt = iff_pkg::CH_NUL;
    sl_nxt      = 1'b0;
    mag         = in_ch.value;
    if (in_ch.signed_conv) begin
      if (in_ch.value[iff_pkg::VALUE_W-1]) begin
        sign_ch_nxt = iff_pkg::CH_MINUS;
        sl_nxt      = 1'b1;
        mag         = '0 - in_ch.value;
      end else if (in_ch.force_plus) begin
        sign_ch_nxt = iff_pkg::CH_PLUS;
        sl_nxt      = 1'b1;
      end else if (in_ch.space_sign) begin
        sign_ch_nxt = iff_pkg::CH_SPACE;
        sl_nxt      = 1'b1;
      end
    end
    pl_nxt = 2'd0;
    if (in_ch.alt_prefix) begin
      if (in_ch.base == iff_pkg::BASE_HEX) begin
        pl_nxt = 2'd2;
      end else if (in_ch.base == iff_pkg::BASE_OCT) begin
        pl_nxt = 2'd1;
      end
    end
  end

  // Spec capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r    <= in_ch.base;
      fw_r      <= in_ch.field_width;
      md_r      <= in_ch.min_digits;
      left_r    <= in_ch.left_align;
      zpad_r    <= in_ch.zero_pad & ~in_ch.left_align;
      upper_r   <= in_ch.upper_digits;
      sign_ch_r <= sign_ch_nxt;
      sl_r      <= sl_nxt;
      pl_r      <= pl_nxt;
    end
  end

  // Quotient and digit count.
  always_comb begin
    quot_nxt = quot_r;
    dc_nxt   = dc_r;
    if (cmd.load) begin
      quot_nxt = mag;
      dc_nxt   = '0;
    end else if (cmd.store_zero) begin
      dc_nxt = CW'(1);
    end else if (cmd.store_digit) begin
      quot_nxt = div_q;
      dc_nxt   = dc_r + 1'b1;
    end
  end

  // Field length arithmetic for the layout.
  always_comb begin
    dc_len  = LEN_W'(dc_r);
    md_len  = LEN_W'(md_r);
    fw_len  = LEN_W'(fw_r);
    prec    = (md_len > dc_len) ? md_len : dc_len;
    fixed   = LEN_W'(sl_r) + LEN_W'(pl_r) + prec;
    pad     = (fw_len > fixed) ? fw_len - fixed : '0;
    b2_c    = lead_r + LEN_W'(sl_r);
    b3_c    = b2_c + LEN_W'(pl_r);
    b4_c    = b3_c + zfill_r + pzero_r;
    b5_c    = b4_c + dc_len;
    total_c = b5_c + trail_r;
  end

  // Character at the current position.
  always_comb begin
    in_digits = (pos_r >= b4_r) && (pos_r < b5_r);
    emit_last = (pos_r + LEN_W'(1)) == limit_r;
    if (pos_r < b1_r) begin
      char_c = iff_pkg::CH_SPACE;
    end else if (pos_r < b2_r) begin
      char_c = sign_ch_r;
    end else if (pos_r < b3_r) begin
      char_c = (pos_r == b2_r) ? iff_pkg::CH_ZERO : iff_pkg::CH_X;
    end else if (pos_r < b4_r) begin
      char_c = iff_pkg::CH_ZERO;
    end else if (in_digits) begin
      char_c = iff_pkg::digit_char(rd_data_r, upper_r);
    end else begin
      char_c = iff_pkg::CH_SPACE;
    end
  end

  // Digit read pointer walks from the most significant digit down.
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    pos_nxt    = pos_r;
    if (cmd.size) begin
      rd_idx_nxt = AW'(dc_r - CW'(1));
      pos_nxt    = '0;
    end else if (cmd.emit) begin
      pos_nxt = pos_r + LEN_W'(1);
      if (in_digits) begin
        rd_idx_nxt = rd_idx_r - AW'(1);
      end
    end
  end

  // Digit store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.store_zero) begin
      digit_mem[0] <= '0;
    end else if (cmd.store_digit && (dc_r < CW'(MAX_DIGITS))) begin
      digit_mem[dc_r[AW-1:0]] <= div_rem;
    end
    rd_data_r <= digit_mem[rd_idx_nxt];
  end

  // Layout registers.
  always_ff @(posedge clk) begin
    if (cmd.size) begin
      lead_r  <= (!zpad_r && !left_r) ? pad : '0;
      zfill_r <= zpad_r ? pad : '0;
      trail_r <= left_r ? pad : '0;
      pzero_r <= prec - dc_len;
    end
    if (cmd.bound) begin
      b1_r    <= lead_r;
      b2_r    <= b2_c;
      b3_r    <= b3_c;
      b4_r    <= b4_c;
      b5_r    <= b5_c;
      limit_r <= (total_c > OUT_LIMIT) ? OUT_LIMIT : total_c;
    end
  end

  // Control registers of the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quot_r      <= '0;
      dc_r        <= '0;
      pos_r       <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      quot_r   <= quot_nxt;
      dc_r     <= dc_nxt;
      pos_r    <= pos_nxt;
      rd_idx_r <= rd_idx_nxt;
      if (cmd.emit || cmd.emit_err) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      out_char_r <= iff_pkg::CH_NUL;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end else if (cmd.emit) begin
      out_char_r <= char_c;
      out_last_r <= emit_last;
      out_err_r  <= 1'b0;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.char_out = out_char_r;
  assign out_ch.last     = out_last_r;
  assign out_ch.error    = out_err_r;

  // Status to the controller.
  always_comb begin
    sts.base_bad    = (base_r < iff_pkg::BASE_MIN) || (base_r > iff_pkg::BASE_MAX);
    sts.quot_zero   = (quot_r == '0);
    sts.dc_zero     = (dc_r == '0);
    sts.digits_full = (dc_r == CW'(MAX_DIGITS));
    sts.div_done    = div_done;
    sts.slot_free   = !out_valid_r || out_ch.ready;
    sts.emit_last   = emit_last;
  end

endmodule

[rtl/core/iff_ctrl.sv]
// ---------------------------------------------------------------------------
// iff_ctrl
// Controller: sequences capture, digit extraction, layout and character
// emission of one transaction at a time.
// ---------------------------------------------------------------------------
module iff_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  iff_pkg::iff_sts_t   sts,
  output iff_pkg::iff_cmd_t   cmd
);

  iff_pkg::iff_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iff_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iff_pkg::S_IDLE: begin
        if (in_valid) state_nxt = iff_pkg::S_START;
      end
      iff_pkg::S_START: begin
        state_nxt = sts.base_bad ? iff_pkg::S_ERROR : iff_pkg::S_CHECK;
      end
      iff_pkg::S_CHECK: begin
        if (sts.quot_zero || sts.digits_full) begin
          state_nxt = iff_pkg::S_SIZE;
        end else begin
          state_nxt = iff_pkg::S_DIVIDE;
        end
      end
      iff_pkg::S_DIVIDE: begin
        if (sts.div_done) state_nxt = iff_pkg::S_CHECK;
      end
      iff_pkg::S_SIZE: begin
        state_nxt = iff_pkg::S_BOUND;
      end
      iff_pkg::S_BOUND: begin
        state_nxt = iff_pkg::S_EMIT;
      end
      iff_pkg::S_EMIT: begin
        if (sts.slot_free && sts.emit_last) state_nxt = iff_pkg::S_IDLE;
      end
      iff_pkg::S_ERROR: begin
        if (sts.slot_free) state_nxt = iff_pkg::S_IDLE;
      end
      default: state_nxt = iff_pkg::S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      iff_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      iff_pkg::S_START: begin
      end
      iff_pkg::S_CHECK: begin
        if (sts.quot_zero) begin
          cmd.store_zero = sts.dc_zero;
        end else if (!sts.digits_full) begin
          cmd.start_div = 1'b1;
        end
      end
      iff_pkg::S_DIVIDE: begin
        cmd.store_digit = sts.div_done;
      end
      iff_pkg::S_SIZE: begin
        cmd.size = 1'b1;
      end
      iff_pkg::S_BOUND: begin
        cmd.bound = 1'b1;
      end
      iff_pkg::S_EMIT: begin
        cmd.emit = sts.slot_free;
      end
      iff_pkg::S_ERROR: begin
        cmd.emit_err = sts.slot_free;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/integer_field_formatter.sv]
// ---------------------------------------------------------------------------
// integer_field_formatter
// Formats one 32-bit integer printf-style and emits the field one ASCII
// character per result transaction, with last on the final character.
// ---------------------------------------------------------------------------
// One input transaction is processed at a time. Digits come one by one
// from a single bit-serial divider; a value has at most 32 digits, for
// base 2, and the field at most MAX_OUT_CHARS characters, emitted one
// character per cycle while the sink is ready. A base outside 2..36 yields
// a single result with error set, emitted from the error state once the
// output register is free. A finished character waits in the output
// register, and the next transaction is accepted as soon as the last
// character has been loaded there. Fields longer than MAX_OUT_CHARS are
// cut, with last on the final character emitted; values needing more than
// MAX_DIGITS digits lose their most significant digits.
module integer_field_formatter #(
  parameter int MAX_DIGITS    = 32,
  parameter int MAX_OUT_CHARS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  iff_in_if.sink    in_ch,
  iff_out_if.source out_ch
);

  iff_pkg::iff_cmd_t cmd;
  iff_pkg::iff_sts_t sts;

  // Sequencing.
  iff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Conversion and output.
  iff_dpath #(
    .MAX_DIGITS    (MAX_DIGITS),
    .MAX_OUT_CHARS (MAX_OUT_CHARS)
  ) u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

[rtl/core/iff_checker.sv]
// ---------------------------------------------------------------------------
// iff_checker
// Port-level checks of the integer field formatter, bound to the top level.
// ---------------------------------------------------------------------------
module iff_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [iff_pkg::CHAR_W-1:0]  out_char,
  input logic                        out_last,
  input logic                        out_error
);

  // Only one transaction is in work: no acceptance right after another.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted in two consecutive cycles");

  // While a field is still being emitted, no new transaction is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> !in_ready)
    else $error("input ready in the middle of a field");

  // An error result is a lone NUL that closes the field.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_last && (out_char == iff_pkg::CH_NUL)))
    else $error("error result is not a single NUL");

  // A stalled character is held.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind integer_field_formatter iff_checker u_iff_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.char_out),
  .out_last  (out_ch.last),
  .out_error (out_ch.error)
);

[sim/iff_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// iff_tb_checker
// Watches both channels of the integer field formatter, works out the
// characters of every accepted conversion and compares each result
// transaction with the oldest character still expected.
// ---------------------------------------------------------------------------
module iff_tb_checker #(
  parameter int MAX_DIGITS    = 32,
  parameter int MAX_OUT_CHARS = 64
) (
  input  logic clk,
  input  logic rst_n,
  iff_in_if    in_ch,
  iff_out_if   out_ch,
  output int   pending,
  output int   fail_count
);

  typedef struct packed {
    logic [iff_pkg::CHAR_W-1:0] ch;
    logic                       last;
    logic                       error;
  } fmt_char_t;

  localparam string LOWER_SET = "0123456789abcdefghijklmnopqrstuvwxyz";
  localparam string UPPER_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  // Characters still owed by the block, oldest first.
  fmt_char_t expected_chars[$];
  // Characters of the field being built, before last is marked.
  logic [iff_pkg::CHAR_W-1:0] field_chars[$];

  // Characters beyond the output limit are cut off.
  function automatic void put_char(input logic [iff_pkg::CHAR_W-1:0] ch);
    if (field_chars.size() < MAX_OUT_CHARS) begin
      field_chars.push_back(ch);
    end
  endfunction

  function automatic void put_run(input logic [iff_pkg::CHAR_W-1:0] ch, input int n);
    for (int i = 0; i < n; i++) begin
      put_char(ch);
    end
  endfunction

  // Builds the formatted field of the transaction on the input channel.
  function automatic void format_field();
    logic [iff_pkg::VALUE_W-1:0] mag;
    logic [iff_pkg::VALUE_W-1:0] quot;
    logic [iff_pkg::VALUE_W-1:0] radix;
    logic [iff_pkg::DIGIT_W-1:0] digs[MAX_DIGITS];
    logic [iff_pkg::CHAR_W-1:0]  sign_ch;
    logic                        lft;
    logic                        zp;
    int                          pad;
    int                          prec;
    int                          n_dig;
    string                       digit_set;
    fmt_char_t                   entry;

    // An unsupported base yields one flagged NUL.
    if (in_ch.base < iff_pkg::BASE_MIN || in_ch.base > iff_pkg::BASE_MAX) begin
      entry.ch    = iff_pkg::CH_NUL;
      entry.last  = 1'b1;
      entry.error = 1'b1;
      expected_chars.push_back(entry);
      return;
    end

    pad       = int'(in_ch.field_width);
    lft       = in_ch.left_align;
    zp        = in_ch.zero_pad && !lft;
    digit_set = in_ch.upper_digits ? UPPER_SET : LOWER_SET;
    mag       = in_ch.value;
    sign_ch   = iff_pkg::CH_NUL;

    // Sign character; the most negative value keeps magnitude 2^31.
    if (in_ch.signed_conv) begin
      if (in_ch.value[iff_pkg::VALUE_W-1]) begin
        sign_ch = iff_pkg::CH_MINUS;
        mag     = -in_ch.value;
        pad--;
      end else if (in_ch.force_plus) begin
        sign_ch = iff_pkg::CH_PLUS;
        pad--;
      end else if (in_ch.space_sign) begin
        sign_ch = iff_pkg::CH_SPACE;
        pad--;
      end
    end

    if (in_ch.alt_prefix) begin
      if (in_ch.base == iff_pkg::BASE_HEX) begin
        pad -= 2;
      end else if (in_ch.base == iff_pkg::BASE_OCT) begin
        pad -= 1;
      end
    end

    // Digits, least significant first; zero still gets one digit.
    radix = iff_pkg::VALUE_W'(in_ch.base);
    quot  = mag;
    n_dig = 0;
    if (quot == '0) begin
      digs[0] = '0;
      n_dig   = 1;
    end else begin
      while (quot != '0 && n_dig < MAX_DIGITS) begin
        digs[n_dig] = iff_pkg::DIGIT_W'(quot % radix);
        quot        = quot / radix;
        n_dig++;
      end
    end

    prec = int'(in_ch.min_digits);
    if (prec < n_dig) begin
      prec = n_dig;
    end
    pad -= prec;

    field_chars.delete();
    if (!zp && !lft) begin
      put_run(iff_pkg::CH_SPACE, pad);
      pad = 0;
    end
    if (sign_ch != iff_pkg::CH_NUL) begin
      put_char(sign_ch);
    end
    if (in_ch.alt_prefix) begin
      if (in_ch.base == iff_pkg::BASE_OCT) begin
        put_char(iff_pkg::CH_ZERO);
      end else if (in_ch.base == iff_pkg::BASE_HEX) begin
        put_char(iff_pkg::CH_ZERO);
        put_char(iff_pkg::CH_X);
      end
    end
    if (!lft) begin
      put_run(iff_pkg::CH_ZERO, pad);
      pad = 0;
    end
    put_run(iff_pkg::CH_ZERO, prec - n_dig);
    for (int k = n_dig; k > 0; k--) begin
      put_char(iff_pkg::CHAR_W'(digit_set[digs[k-1]]));
    end
    put_run(iff_pkg::CH_SPACE, pad);

    // Hand the field over, with last on its final character.
    foreach (field_chars[i]) begin
      entry.ch    = field_chars[i];
      entry.last  = (i == field_chars.size() - 1);
      entry.error = 1'b0;
      expected_chars.push_back(entry);
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Predict on every input transaction, compare on every result transaction.
  always @(posedge clk) begin
    fmt_char_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        format_field();
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result: char_out 0x%0h last %0b error %0b",
                 out_ch.char_out, out_ch.last, out_ch.error);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          check_field("char_out", want.ch, out_ch.char_out);
          check_field("last", want.last, out_ch.last);
          check_field("error", want.error, out_ch.error);
        end
      end
    end
    pending <= expected_chars.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the integer field formatter: directed corner
// conversions, then random specs with random gaps on both channels. The
// checker beside the block does all prediction and comparison.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int MAX_DIGITS    = 32;
  localparam int MAX_OUT_CHARS = 64;
  localparam int RANDOM_ITEMS  = 145;
  localparam int IDLE_PCT      = 18;
  localparam int STALL_LIMIT   = 6000;
  localparam int DRAIN_CYCLES  = 40;

  // Flag bits of a directed spec, in the order signed, plus, space, alt,
  // zero pad, left align, upper case.
  localparam logic [6:0] F_NONE   = 7'b0000000;
  localparam logic [6:0] F_SIGNED = 7'b1000000;
  localparam logic [6:0] F_PLUS   = 7'b0100000;
  localparam logic [6:0] F_SPACE  = 7'b0010000;
  localparam logic [6:0] F_ALT    = 7'b0001000;
  localparam logic [6:0] F_ZPAD   = 7'b0000100;
  localparam logic [6:0] F_LEFT   = 7'b0000010;
  localparam logic [6:0] F_UPPER  = 7'b0000001;

  typedef struct packed {
    logic [iff_pkg::VALUE_W-1:0] value;
    logic [iff_pkg::BASE_W-1:0]  base;
    logic [iff_pkg::FW_W-1:0]    field_width;
    logic [iff_pkg::MD_W-1:0]    min_digits;
    logic [6:0]                  flags;
  } fmt_spec_t;

  logic clk;
  logic rst_n;
  int   pending;
  int   fail_count;
  int   quiet_cycles;
  bit   calm;

  iff_in_if  in_ch ();
  iff_out_if out_ch ();

  integer_field_formatter #(
    .MAX_DIGITS   (MAX_DIGITS),
    .MAX_OUT_CHARS(MAX_OUT_CHARS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  iff_tb_checker #(
    .MAX_DIGITS   (MAX_DIGITS),
    .MAX_OUT_CHARS(MAX_OUT_CHARS)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .pending   (pending),
    .fail_count(fail_count)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The result side stalls at random, except during the calm stretch.
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog on cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic fmt_spec_t make_spec(input logic [iff_pkg::VALUE_W-1:0] value,
                                          input int base, input int fw, input int md,
                                          input logic [6:0] flags);
    fmt_spec_t s;
    s.value       = value;
    s.base        = iff_pkg::BASE_W'(base);
    s.field_width = iff_pkg::FW_W'(fw);
    s.min_digits  = iff_pkg::MD_W'(md);
    s.flags       = flags;
    return s;
  endfunction

  // Random spec: mostly common bases and modest sizes, some full-range fields.
  function automatic fmt_spec_t random_spec();
    fmt_spec_t s;
    int        roll;
    case ($urandom_range(4))
      0:       s.value = $urandom_range(300);
      1:       s.value = -iff_pkg::VALUE_W'($urandom_range(1, 300));
      2:       s.value = ($urandom_range(1)) ? 32'h8000_0000 : 32'hFFFF_FFFF;
      default: s.value = $urandom;
    endcase
    roll = $urandom_range(99);
    if (roll < 55) begin
      case ($urandom_range(3))
        0:       s.base = 6'd2;
        1:       s.base = iff_pkg::BASE_OCT;
        2:       s.base = 6'd10;
        default: s.base = iff_pkg::BASE_HEX;
      endcase
    end else if (roll < 92) begin
      s.base = iff_pkg::BASE_W'($urandom_range(iff_pkg::BASE_MIN, iff_pkg::BASE_MAX));
    end else begin
      s.base = iff_pkg::BASE_W'($urandom_range(63));
    end
    s.field_width = ($urandom_range(99) < 85) ? iff_pkg::FW_W'($urandom_range(24))
                                              : iff_pkg::FW_W'($urandom_range(127));
    s.min_digits  = ($urandom_range(99) < 85) ? iff_pkg::MD_W'($urandom_range(12))
                                              : iff_pkg::MD_W'($urandom_range(63));
    s.flags       = 7'($urandom);
    return s;
  endfunction

  // Offers one spec, with a random gap first, and holds it until accepted.
  task automatic send_spec(input fmt_spec_t s);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.value        <= s.value;
    in_ch.base         <= s.base;
    in_ch.field_width  <= s.field_width;
    in_ch.min_digits   <= s.min_digits;
    {in_ch.signed_conv, in_ch.force_plus, in_ch.space_sign, in_ch.alt_prefix,
     in_ch.zero_pad, in_ch.left_align, in_ch.upper_digits} <= s.flags;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
  endtask

  // Main sequence: reset, directed corners, random specs, drain, verdict.
  initial begin
    fmt_spec_t directed[$];

    calm                <= 1'b0;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.value         <= '0;
    in_ch.base          <= '0;
    in_ch.field_width   <= '0;
    in_ch.min_digits    <= '0;
    in_ch.signed_conv   <= 1'b0;
    in_ch.force_plus    <= 1'b0;
    in_ch.space_sign    <= 1'b0;
    in_ch.alt_prefix    <= 1'b0;
    in_ch.zero_pad      <= 1'b0;
    in_ch.left_align    <= 1'b0;
    in_ch.upper_digits  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Zero value, plain and with the hex and octal prefixes.
    directed.push_back(make_spec(32'd0, 10, 0, 0, F_NONE));
    directed.push_back(make_spec(32'd0, 16, 0, 0, F_ALT));
    directed.push_back(make_spec(32'd0, 8, 5, 0, F_ALT | F_ZPAD));
    // Most negative value under signed conversion, and all ones unsigned.
    directed.push_back(make_spec(32'h8000_0000, 10, 0, 0, F_SIGNED));
    directed.push_back(make_spec(32'h8000_0000, 2, 40, 0, F_SIGNED | F_ZPAD));
    directed.push_back(make_spec(32'hFFFF_FFFF, 2, 0, 0, F_NONE));
    directed.push_back(make_spec(32'hFFFF_FFFF, 36, 0, 0, F_UPPER));
    directed.push_back(make_spec(32'hFFFF_FFFF, 36, 0, 0, F_NONE));
    // Bases out of range on both sides.
    directed.push_back(make_spec(32'd123, 0, 0, 0, F_NONE));
    directed.push_back(make_spec(32'd123, 1, 10, 3, F_SIGNED));
    directed.push_back(make_spec(32'd123, 37, 0, 0, F_ALT));
    directed.push_back(make_spec(32'hFFFF_FFFF, 63, 127, 63, 7'h7F));
    // Sign options.
    directed.push_back(make_spec(32'd42, 10, 8, 0, F_SIGNED | F_PLUS | F_ZPAD));
    directed.push_back(make_spec(32'd42, 10, 6, 0, F_SIGNED | F_SPACE));
    directed.push_back(make_spec(-32'd5, 16, 12, 5, F_SIGNED | F_ALT | F_ZPAD));
    directed.push_back(make_spec(32'd42, 10, 0, 0, F_PLUS | F_SPACE));
    // Prefix with padding and case.
    directed.push_back(make_spec(32'd255, 16, 10, 0, F_ALT | F_ZPAD | F_UPPER));
    directed.push_back(make_spec(32'd8, 8, 6, 0, F_ALT));
    directed.push_back(make_spec(32'hBEEF, 16, 10, 0, F_LEFT | F_ZPAD | F_ALT));
    // Fields that fill or overrun the output limit; the overlong ones are cut.
    directed.push_back(make_spec(32'd7, 10, 0, 63, F_SIGNED | F_PLUS));
    directed.push_back(make_spec(32'd99, 10, 127, 0, F_NONE));
    directed.push_back(make_spec(-32'd99, 10, 127, 0, F_SIGNED | F_LEFT));
    directed.push_back(make_spec(32'd1, 16, 127, 61, F_ALT | F_ZPAD));
    // An odd base, and every flag at once.
    directed.push_back(make_spec(32'd123456, 7, 0, 0, F_NONE));
    directed.push_back(make_spec(32'd0, 16, 9, 4, 7'h7F));

    foreach (directed[i]) begin
      send_spec(directed[i]);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 60 && i < 100);
      send_spec(random_spec());
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
